// File: sv/distance_vector_table_update_unit_defines.svh
// assertion macros used by the checker file
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_UNIT_DEFINES_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define DVTU_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dvtu check failed");

// next-cycle implication, sampled on clk, off while in reset
`define DVTU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dvtu check failed");

`endif

// File: sv/dvtu_pkg.sv
// types and constants of the distance vector table update unit
`default_nettype none
package dvtu_pkg;

	localparam logic [15:0] COST_MAX = 16'hFFFF;

	localparam logic [1:0] ST_UNCHANGED = 2'd0;
	localparam logic [1:0] ST_IMPROVED  = 2'd1;
	localparam logic [1:0] ST_ADDED     = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [31:0] dest_address;
		logic [15:0] advertised_cost;
		logic [31:0] neighbour_address;
		logic [31:0] arrival_interface;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot_index;
		logic [15:0] stored_cost;
		logic [31:0] stored_next_hop;
	} out_t;

	// one route table entry
	typedef struct packed {
		logic [31:0] dest;
		logic [15:0] cost;
		logic [31:0] next_hop;
		logic [31:0] iface;
	} route_t;

endpackage
`default_nettype wire

// File: sv/dvtu_table.sv
// route table memory, one write port and one registered read port
`default_nettype none
module dvtu_table #(
	parameter int TABLE_DEPTH = 64,
	parameter int AW          = 6
) (
	input  wire logic            clk,
	input  wire logic            rd_en,
	input  wire logic [AW-1:0]   rd_addr,
	output dvtu_pkg::route_t     rd_data,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire dvtu_pkg::route_t wr_data
);
	import dvtu_pkg::*;

	route_t mem [TABLE_DEPTH];
	route_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// File: sv/dvtu_seq.sv
// scan sequencer with the shared compare unit and the result register
`default_nettype none
module dvtu_seq #(
	parameter int TABLE_DEPTH = 64,
	parameter int AW          = 6,
	parameter int CW          = 7
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire dvtu_pkg::in_t   req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output dvtu_pkg::out_t       rsp,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr,
	input  wire dvtu_pkg::route_t rd_data,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output dvtu_pkg::route_t     wr_data
);
	import dvtu_pkg::*;

	typedef enum logic {
		IDLE,
		SCAN
	} state_t;

	state_t          state_q;
	in_t             item_q;
	logic [15:0]     cand_q;
	logic [CW-1:0]   scan_q;
	logic [CW-1:0]   count_q;
	logic            pend_q;
	logic [AW-1:0]   pend_idx_q;
	out_t            rsp_q;
	logic            rsp_valid_q;

	logic            match;
	logic            cheaper;
	logic            at_end;
	logic            full;
	logic            out_free;
	logic            finish;
	logic            grow;
	logic [15:0]     cand_next;
	logic [AW+5:0]   slot_wide;
	out_t            rsp_next;

	// shared compare unit: destination match and cost compare
	assign match    = pend_q && (rd_data.dest == item_q.dest_address);
	assign cheaper  = rd_data.cost > cand_q;
	assign at_end   = scan_q == count_q;
	assign full     = count_q == CW'(TABLE_DEPTH);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign finish   = (state_q == SCAN) && (match || at_end) && out_free;
	assign grow     = finish && !match && !full;

	assign cand_next = (req.advertised_cost == COST_MAX) ? COST_MAX
		: req.advertised_cost + 16'd1;

	assign rd_en   = (state_q == SCAN) && !match && !at_end;
	assign rd_addr = scan_q[AW-1:0];

	assign wr_en   = finish && (match ? cheaper : !full);
	assign wr_addr = match ? pend_idx_q : count_q[AW-1:0];

	always_comb begin
		wr_data.dest     = item_q.dest_address;
		wr_data.cost     = cand_q;
		wr_data.next_hop = item_q.neighbour_address;
		wr_data.iface    = match ? rd_data.iface : item_q.arrival_interface;
	end

	assign slot_wide = match ? {6'd0, pend_idx_q} : {6'd0, count_q[AW-1:0]};

	always_comb begin
		rsp_next.slot_index      = slot_wide[5:0];
		rsp_next.stored_cost     = cand_q;
		rsp_next.stored_next_hop = item_q.neighbour_address;
		if (match) begin
			if (cheaper) begin
				rsp_next.status = ST_IMPROVED;
			end else begin
				rsp_next.status          = ST_UNCHANGED;
				rsp_next.stored_cost     = rd_data.cost;
				rsp_next.stored_next_hop = rd_data.next_hop;
			end
		end else if (full) begin
			rsp_next.status          = ST_FULL;
			rsp_next.slot_index      = 6'd0;
			rsp_next.stored_cost     = 16'd0;
			rsp_next.stored_next_hop = 32'd0;
		end else begin
			rsp_next.status = ST_ADDED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			item_q      <= '0;
			cand_q      <= '0;
			scan_q      <= '0;
			count_q     <= '0;
			pend_q      <= 1'b0;
			pend_idx_q  <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && !finish) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (req_valid) begin
						item_q  <= req;
						cand_q  <= cand_next;
						scan_q  <= '0;
						pend_q  <= 1'b0;
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (finish) begin
						rsp_q       <= rsp_next;
						rsp_valid_q <= 1'b1;
						state_q     <= IDLE;
						if (grow) begin
							count_q <= count_q + CW'(1);
						end
					end else if (rd_en) begin
						pend_q     <= 1'b1;
						pend_idx_q <= scan_q[AW-1:0];
						scan_q     <= scan_q + CW'(1);
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign req_stall = state_q != IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// File: sv/distance_vector_table_update_unit.sv
// top level of the distance vector route table update unit
//
//  channel | direction | handshake              | word
//  req     | in        | req_valid / req_stall  | dvtu_pkg::in_t
//  rsp     | out       | rsp_valid / rsp_stall  | dvtu_pkg::out_t
//
// one advertisement at a time: the stored entries are read in slot order, up to and
//   including a hit (all of them on a miss), before the result is registered
// the next word is taken only once the result is loaded; the scan is paced by the
//   single read port of the route table memory
// req_stall is high from acceptance until the result is loaded into the output register
// a stalled result holds; the scan waits at its last step until the output is free
// arst_n clears the entry count and control; the table itself needs no clearing
`default_nettype none
module distance_vector_table_update_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire dvtu_pkg::in_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output dvtu_pkg::out_t rsp
);
	import dvtu_pkg::*;

	// slot address width and entry count width (count must reach TABLE_DEPTH)
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// read port of the table, fed by the scan pointer
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	route_t        rd_data;

	// write port: append on a miss while the table has room, rewrite cost and next hop on an improvement
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	route_t        wr_data;

	// sequencer: walks the stored entries, compares, decides and builds the result word
	dvtu_seq #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW),
		.CW          (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// route store: destination, cost, next hop and arrival interface per slot
	dvtu_table #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule
`default_nettype wire

// File: sv/dvtu_chk.sv
// port checker of the route table update unit and its bind
`default_nettype none
`include "distance_vector_table_update_unit_defines.svh"
module dvtu_chk (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_valid,
	input wire logic      req_stall,
	input wire dvtu_pkg::in_t  req,
	input wire logic      rsp_valid,
	input wire logic      rsp_stall,
	input wire dvtu_pkg::out_t rsp
);
	import dvtu_pkg::*;

	// a stalled result word holds
	`DVTU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	// the unit is busy right after taking an advertisement
	`DVTU_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
	// a dropped entry reports an empty slot, cost and next hop
	`DVTU_ASSERT_IMPL(a_full_zero, rsp_valid && rsp.status == ST_FULL,
		rsp.slot_index == 6'd0 && rsp.stored_cost == 16'd0 && rsp.stored_next_hop == 32'd0)
	// a written cost is always at least one
	`DVTU_ASSERT_IMPL(a_written_cost,
		rsp_valid && (rsp.status == ST_ADDED || rsp.status == ST_IMPROVED),
		rsp.stored_cost != 16'd0)

endmodule

bind distance_vector_table_update_unit dvtu_chk u_chk (.*);
`default_nettype wire
